>>> hdl/syr_pkg.sv
// Shared types and constants for the semiplanar YUV to RGB converter.
// Holds the per-stage payload structs and the fixed conversion coefficients.
// No dependencies.
`default_nettype none

package syr_pkg;

  // Pixel format codes
  localparam logic FMT_NV21 = 1'b0;
  localparam logic FMT_P010 = 1'b1;

  // Field widths
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned LUMA_W = 11;  // offset luma, signed
  localparam int unsigned CHR_W  = 10;  // centered chroma, signed
  localparam int unsigned P8_W   = 18;  // 8-bit mode products
  localparam int unsigned P10_W  = 24;  // 10-bit mode products and sums
  localparam int unsigned PRE_W  = 12;  // channel value before saturation

  // 8-bit mode coefficients, applied then shifted right by 8
  localparam logic signed [P8_W-1:0] C8_RV = 18'sd359;
  localparam logic signed [P8_W-1:0] C8_GU = 18'sd88;
  localparam logic signed [P8_W-1:0] C8_GV = 18'sd183;
  localparam logic signed [P8_W-1:0] C8_BU = 18'sd454;
  localparam int unsigned SH8 = 8;

  // 10-bit mode coefficients, rounding term and total shift (10 then 2)
  localparam logic signed [P10_W-1:0] C10_Y   = 24'sd1192;
  localparam logic signed [P10_W-1:0] C10_RV  = 24'sd1836;
  localparam logic signed [P10_W-1:0] C10_GU  = 24'sd218;
  localparam logic signed [P10_W-1:0] C10_GV  = 24'sd547;
  localparam logic signed [P10_W-1:0] C10_BU  = 24'sd2163;
  localparam logic signed [P10_W-1:0] C10_RND = 24'sd512;
  localparam int unsigned SH10 = 12;

  // Luma offset in 10-bit mode
  localparam logic signed [LUMA_W-1:0] LUMA_OFS10 = 11'sd64;

  // Stage 1: decoded samples
  typedef struct packed {
    logic                     fmt;
    logic signed [LUMA_W-1:0] luma;
    logic signed [CHR_W-1:0]  cu;
    logic signed [CHR_W-1:0]  cv;
  } syr_dec_t;

  // Stage 2: products for both modes
  typedef struct packed {
    logic                     fmt;
    logic signed [LUMA_W-1:0] luma;
    logic signed [P8_W-1:0]   p8_rv;
    logic signed [P8_W-1:0]   p8_gu;
    logic signed [P8_W-1:0]   p8_gv;
    logic signed [P8_W-1:0]   p8_bu;
    logic signed [P10_W-1:0]  p10_y;
    logic signed [P10_W-1:0]  p10_rv;
    logic signed [P10_W-1:0]  p10_gu;
    logic signed [P10_W-1:0]  p10_gv;
    logic signed [P10_W-1:0]  p10_bu;
  } syr_prod_t;

  // Stage 3: channel values before saturation
  typedef struct packed {
    logic signed [PRE_W-1:0] red;
    logic signed [PRE_W-1:0] green;
    logic signed [PRE_W-1:0] blue;
  } syr_pre_t;

endpackage

`default_nettype wire

>>> hdl/syr_datapath.sv
// Three-stage conversion datapath: decode, multiply, sum and shift.
// Depends on syr_pkg for payload structs and coefficients.
`default_nettype none

module syr_datapath
  import syr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fmt,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] luma_word,
  input  wire logic [WORD_W-1:0] chroma_first_word,
  input  wire logic [WORD_W-1:0] chroma_second_word,
  output logic                   pre_valid,
  input  wire logic              pre_ready,
  output syr_pre_t               pre
);

  logic      s1_valid_r, s2_valid_r, s3_valid_r;
  logic      s1_ready, s2_ready, s3_ready;
  syr_dec_t  s1_r, s1_nxt;
  syr_prod_t s2_r, s2_nxt;
  syr_pre_t  s3_r, s3_nxt;

  logic signed [P10_W-1:0] sum10_r, sum10_g, sum10_b;
  logic signed [P8_W-1:0]  sum8_g;

  // A stage takes new data when it is empty or its content moves on
  assign s3_ready = !s3_valid_r || pre_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Decode: pick bits by mode, flip the chroma MSB to center it
  always_comb begin
    s1_nxt.fmt = fmt;
    if (fmt == FMT_P010) begin
      s1_nxt.luma = $signed({1'b0, luma_word[15:6]}) - LUMA_OFS10;
      s1_nxt.cu   = $signed({~chroma_first_word[15], chroma_first_word[14:6]});
      s1_nxt.cv   = $signed({~chroma_second_word[15], chroma_second_word[14:6]});
    end else begin
      s1_nxt.luma = $signed({3'b000, luma_word[7:0]});
      s1_nxt.cv   = CHR_W'($signed({~chroma_first_word[7], chroma_first_word[6:0]}));
      s1_nxt.cu   = CHR_W'($signed({~chroma_second_word[7], chroma_second_word[6:0]}));
    end
  end

  // Multiply: constant products for both modes
  always_comb begin
    s2_nxt.fmt    = s1_r.fmt;
    s2_nxt.luma   = s1_r.luma;
    s2_nxt.p8_rv  = P8_W'(s1_r.cv) * C8_RV;
    s2_nxt.p8_gu  = P8_W'(s1_r.cu) * C8_GU;
    s2_nxt.p8_gv  = P8_W'(s1_r.cv) * C8_GV;
    s2_nxt.p8_bu  = P8_W'(s1_r.cu) * C8_BU;
    s2_nxt.p10_y  = P10_W'(s1_r.luma) * C10_Y;
    s2_nxt.p10_rv = P10_W'(s1_r.cv) * C10_RV;
    s2_nxt.p10_gu = P10_W'(s1_r.cu) * C10_GU;
    s2_nxt.p10_gv = P10_W'(s1_r.cv) * C10_GV;
    s2_nxt.p10_bu = P10_W'(s1_r.cu) * C10_BU;
  end

  // Sum and shift; arithmetic shifts floor toward minus infinity
  always_comb begin
    sum10_r = s2_r.p10_y + s2_r.p10_rv + C10_RND;
    sum10_g = s2_r.p10_y - s2_r.p10_gu - s2_r.p10_gv + C10_RND;
    sum10_b = s2_r.p10_y + s2_r.p10_bu + C10_RND;
    sum8_g  = s2_r.p8_gu + s2_r.p8_gv;
    if (s2_r.fmt == FMT_P010) begin
      s3_nxt.red   = PRE_W'(sum10_r >>> SH10);
      s3_nxt.green = PRE_W'(sum10_g >>> SH10);
      s3_nxt.blue  = PRE_W'(sum10_b >>> SH10);
    end else begin
      s3_nxt.red   = PRE_W'(s2_r.luma) + PRE_W'(s2_r.p8_rv >>> SH8);
      s3_nxt.green = PRE_W'(s2_r.luma) - PRE_W'(sum8_g >>> SH8);
      s3_nxt.blue  = PRE_W'(s2_r.luma) + PRE_W'(s2_r.p8_bu >>> SH8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1_r <= s1_nxt;
    if (s2_ready) s2_r <= s2_nxt;
    if (s3_ready) s3_r <= s3_nxt;
  end

  assign pre_valid = s3_valid_r;
  assign pre       = s3_r;

endmodule

`default_nettype wire

>>> hdl/semiplanar_yuv_to_rgb_core.sv
// Top level of the semiplanar YUV to RGB converter: config register,
// conversion datapath and saturating output register.
// Depends on syr_pkg and syr_datapath.
//
// Usage:
//   Input stream (in_*): one pixel per transaction, the luma word and the
//   chroma pair shared by its pixel pair. Output stream (out_*): one RGB
//   pixel per transaction, in input order.
//   cfg_wr_en / cfg_wr_data write pixel_format (0 = NV21, 1 = P010); write
//   it only while no transaction is in flight.
//   Pipeline: a result passes through the decode, multiply, sum/shift and
//   saturate/output register stages in turn.
//   Throughput: one pixel per clock while out_tready stays high; every stage
//   is a register with its own valid bit, and the constant multipliers sit in a single stage.
//   Reset (rst_n low, synchronous): clear all valid bits and return
//   pixel_format to NV21.
//   Stall: when out_tready is low, hold the output; the stages behind it
//   keep filling until each holds a pixel, then in_tready drops. Nothing
//   is dropped or repeated.
`default_nettype none

module semiplanar_yuv_to_rgb_core
  import syr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_wr_data,   // pixel_format
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,      // luma_word, chroma_first_word, chroma_second_word
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata      // red, green, blue
);

  logic     fmt_r;
  logic     pre_valid, pre_ready;
  syr_pre_t pre;

  logic              out_valid_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;

  // Clamp a signed channel value to 0..255
  function automatic logic [CHAN_W-1:0] sat8(input logic signed [PRE_W-1:0] x);
    logic [CHAN_W-1:0] res;
    priority if (x < 0)                       res = '0;
    else if (x > $signed(PRE_W'(8'hFF)))      res = '1;
    else                                      res = x[CHAN_W-1:0];
    return res;
  endfunction

  // Keep only bit 0 of a format write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_NV21;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data[0];
    end
  end

  syr_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .fmt                (fmt_r),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .luma_word          (in_tdata[15:0]),
    .chroma_first_word  (in_tdata[31:16]),
    .chroma_second_word (in_tdata[47:32]),
    .pre_valid          (pre_valid),
    .pre_ready          (pre_ready),
    .pre                (pre)
  );

  // Output register frees up when empty or when its transaction completes
  assign pre_ready = !out_valid_r || out_tready;

  always_comb begin
    red_nxt   = sat8(pre.red);
    green_nxt = sat8(pre.green);
    blue_nxt  = sat8(pre.blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pre_ready) begin
      out_valid_r <= pre_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_ready) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {blue_r, green_r, red_r};

endmodule

`default_nettype wire

>>> bench/syr_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for semiplanar_yuv_to_rgb_core: watches the config port and both streams,
// predicts each RGB pixel and compares it with the one the core returns.
// Depends on syr_pkg for the pixel format codes and channel width.

module syr_pixel_checker
  import syr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,     // luma_word, chroma_first_word, chroma_second_word
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,    // red, green, blue
  output int               fail_count,
  output int               rgb_pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  logic fmt_shadow = FMT_NV21;
  rgb_t rgb_due_q[$];

  function automatic logic [CHAN_W-1:0] clamp_chan(input int x);
    if (x < 0) return '0;
    if (x > 255) return 8'd255;
    return CHAN_W'(x);
  endfunction

  function automatic rgb_t yuv_to_rgb(input logic fmt, input logic [15:0] luma_w,
                                      input logic [15:0] first_w, input logic [15:0] second_w);
    int   y, u, v, r, g, b;
    rgb_t px;
    if (fmt == FMT_NV21) begin
      // low bytes only, V first; >>> on int floors toward minus infinity
      y = int'(luma_w[7:0]);
      v = int'(first_w[7:0]) - 128;
      u = int'(second_w[7:0]) - 128;
      r = y + ((359 * v) >>> 8);
      g = y - ((88 * u + 183 * v) >>> 8);
      b = y + ((454 * u) >>> 8);
    end else begin
      // upper ten bits, U first, rounded then shifted by 10 and by 2
      y = int'(luma_w[15:6]) - 64;
      u = int'(first_w[15:6]) - 512;
      v = int'(second_w[15:6]) - 512;
      r = ((1192 * y + 1836 * v + 512) >>> 10) >>> 2;
      g = ((1192 * y - 218 * u - 547 * v + 512) >>> 10) >>> 2;
      b = ((1192 * y + 2163 * u + 512) >>> 10) >>> 2;
    end
    px.red   = clamp_chan(r);
    px.green = clamp_chan(g);
    px.blue  = clamp_chan(b);
    return px;
  endfunction

  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    if (!rst_n) begin
      fmt_shadow <= FMT_NV21;
      rgb_due_q.delete();
      fail_count  <= 0;
      rgb_pending <= 0;
    end else begin
      if (cfg_wr_en) fmt_shadow <= cfg_wr_data[0];
      // compare before pushing, so a fresh pixel never meets its own result
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (rgb_due_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     got.red, got.green, got.blue);
          fail_count <= fail_count + 1;
        end else begin
          want = rgb_due_q.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        rgb_due_q.push_back(yuv_to_rgb(fmt_shadow, in_tdata[15:0], in_tdata[31:16],
                                       in_tdata[47:32]));
      rgb_pending <= rgb_due_q.size();
    end
  end

endmodule

>>> bench/tb_semiplanar_yuv_to_rgb_core.sv
`timescale 1ns / 1ps
// Top of the semiplanar_yuv_to_rgb_core bench: clock, reset, stimulus and verdict.
// Depends on syr_pkg, the core and syr_pixel_checker, which does all prediction.

module tb_semiplanar_yuv_to_rgb_core
  import syr_pkg::*;
();

  localparam int DRAIN_CYCLES     = 8;    // margin after the last result returns
  localparam int RANDOM_PHASES    = 6;
  localparam int PIXELS_PER_PHASE = 230;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [0:0]  cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;   // luma_word, chroma_first_word, chroma_second_word
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // red, green, blue

  int   fail_count;
  int   rgb_pending;
  logic fmt_now = FMT_NV21;
  bit   no_idle = 1'b0;            // both sides skip their idle cycles while set

  semiplanar_yuv_to_rgb_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  syr_pixel_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .rgb_pending(rgb_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up long after the slowest correct run would have ended.
  initial begin
    #4_000_000;
    $display("FAIL semiplanar_yuv_to_rgb_core");
    $finish;
  end

  // Offer one pixel: idle a random number of cycles, then hold it until the core takes it.
  // Entered and left at a falling edge.
  task automatic send_pixel(input logic [47:0] px);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted pixel has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (rgb_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write pixel_format; only ever called with the core idle.
  task automatic write_format(input logic fmt);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fmt_now = fmt;
  endtask

  // Random pixel with every word bit free; most items pull the chroma toward the
  // middle of the active mode so that the channels are not all clipped.
  function automatic logic [47:0] random_pixel(input logic fmt);
    logic [15:0] luma_w, first_w, second_w;
    luma_w   = 16'($urandom);
    first_w  = 16'($urandom);
    second_w = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      if (fmt == FMT_NV21) begin
        first_w[7:0]  = 8'($urandom_range(88, 168));
        second_w[7:0] = 8'($urandom_range(88, 168));
      end else begin
        first_w[15:6]  = 10'($urandom_range(362, 662));
        second_w[15:6] = 10'($urandom_range(362, 662));
      end
    end
    return {second_w, first_w, luma_w};
  endfunction

  // Sink: stall a random number of cycles before each pixel, then take it.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // NV21 corners: {second (U), first (V), luma}
    write_format(FMT_NV21);
    send_pixel({16'h0000, 16'h0000, 16'h0000});
    send_pixel({16'h00FF, 16'h00FF, 16'h00FF});
    send_pixel({16'h0080, 16'h0080, 16'h0000});   // black, neutral chroma
    send_pixel({16'h0080, 16'h0080, 16'h00FF});   // white, neutral chroma
    send_pixel({16'h0000, 16'h00FF, 16'h0080});   // V high, U low
    send_pixel({16'h00FF, 16'h0000, 16'h0080});   // U high, V low
    send_pixel({16'hFF80, 16'hFF80, 16'hFF10});   // high bytes must be ignored
    send_pixel({16'hAA7F, 16'h5581, 16'h3C81});   // small negative terms floor down
    send_pixel({16'h0081, 16'h007F, 16'h0001});
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel({16'h8000, 16'h0001, 16'h00EB});
    wait_drained();

    // P010 corners: {second (V), first (U), luma}
    write_format(FMT_P010);
    send_pixel({16'h0000, 16'h0000, 16'h0000});   // luma far below its offset
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel({16'h8000, 16'h8000, 16'h1000});   // luma right at its offset
    send_pixel({16'h8000, 16'h8000, 16'h0FC0});   // luma one below its offset
    send_pixel({16'h8000, 16'h8000, 16'hEB00});   // nominal white
    send_pixel({16'hFFC0, 16'h0000, 16'h8000});   // V high, U low
    send_pixel({16'h0000, 16'hFFC0, 16'h8000});   // U high, V low
    send_pixel({16'h803F, 16'h803F, 16'h103F});   // low six bits must be ignored
    send_pixel({16'h7FC0, 16'h8040, 16'h4000});
    send_pixel({16'h0000, 16'h0000, 16'hFFC0});
    send_pixel({16'hFFC0, 16'hFFC0, 16'h0000});
    wait_drained();

    // Random phases, alternating format; drain now and then mid-phase for pressure.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_format(phase[0] ? FMT_P010 : FMT_NV21);
      for (n = 0; n < PIXELS_PER_PHASE; n++) begin
        if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_pixel(random_pixel(fmt_now));
      end
      no_idle = 1'b0;
      wait_drained();
    end

    if (fail_count == 0 && rgb_pending == 0)
      $display("PASS semiplanar_yuv_to_rgb_core");
    else
      $display("FAIL semiplanar_yuv_to_rgb_core");
    $finish;
  end

endmodule
